### hdl/assert_macros.svh
// assertion shorthands used by lbf_datapath, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define LBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never occur
`define LBF_ASSERT_NEVER(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error(msg);

`endif

### hdl/lbf_pkg.sv
package lbf_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int PORT_COUNT    = 8;
    localparam int ADDRESS_BITS  = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int PORT_W        = 3;
    localparam int MASK_W        = 8;
    localparam int CONF_W        = 4;
    localparam int CFG_W         = 4;
    localparam int STAT_W        = 32;

    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [PORT_W-1:0]       port_t;
    typedef logic [MASK_W-1:0]       mask_t;
    typedef logic [CONF_W-1:0]       conf_t;
    typedef logic [CFG_W-1:0]        cfg_t;
    typedef logic [STAT_W-1:0]       stat_t;
    typedef logic [TABLE_ENTRIES-1:0] row_vec_t;

    localparam conf_t CONF_NEW    = 4'd8;
    localparam conf_t CONF_MAX    = 4'd10;
    localparam cfg_t  PORTS_RESET = 4'd8;
    localparam mask_t MASK_SINGLE = 8'h01;

    typedef struct packed {
        logic load;
        logic src_cmp;
        logic src_sel;
        logic learn;
        logic dst_cmp;
        logic dst_sel;
        logic fwd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // ports 0 .. n-1 active, n forced into 1 .. PORT_COUNT
    function automatic mask_t active_mask(cfg_t ports);
        mask_t m;
        cfg_t  eff;
        eff = ports;
        if (eff == '0)
            eff = cfg_t'(1);
        if (eff > cfg_t'(PORT_COUNT))
            eff = cfg_t'(PORT_COUNT);
        for (int p = 0; p < MASK_W; p++)
            m[p] = (cfg_t'(p) < eff);
        return m;
    endfunction

endpackage

### hdl/lbf_in_if.sv
interface lbf_in_if;
    logic                  valid;
    logic                  ready;
    lbf_pkg::addr_t        source_address;
    lbf_pkg::addr_t        destination_address;
    lbf_pkg::port_t        arrival_port;

    modport source (
        output valid, source_address, destination_address, arrival_port,
        input  ready
    );
    modport sink (
        input  valid, source_address, destination_address, arrival_port,
        output ready
    );
endinterface

### hdl/lbf_out_if.sv
interface lbf_out_if;
    logic                  valid;
    logic                  ready;
    lbf_pkg::mask_t        forward_mask;
    logic                  route_hit;
    logic                  new_route_learned;
    logic                  learn_table_full;
    logic                  alternate_port_seen;
    lbf_pkg::conf_t        route_confidence;
    lbf_pkg::stat_t        route_uses;
    lbf_pkg::stat_t        packets_seen;
    lbf_pkg::stat_t        packets_routed;
    lbf_pkg::stat_t        packets_flooded;
    lbf_pkg::cnt_t         routes_known;

    modport source (
        output valid, forward_mask, route_hit, new_route_learned, learn_table_full,
               alternate_port_seen, route_confidence, route_uses, packets_seen,
               packets_routed, packets_flooded, routes_known,
        input  ready
    );
    modport sink (
        input  valid, forward_mask, route_hit, new_route_learned, learn_table_full,
               alternate_port_seen, route_confidence, route_uses, packets_seen,
               packets_routed, packets_flooded, routes_known,
        output ready
    );
endinterface

### hdl/lbf_ctrl.sv
module lbf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lbf_pkg::dp_status_t    status,
    output lbf_pkg::ctrl_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SRC_CMP = 3'd1;
    localparam logic [2:0] S_SRC_SEL = 3'd2;
    localparam logic [2:0] S_LEARN   = 3'd3;
    localparam logic [2:0] S_DST_CMP = 3'd4;
    localparam logic [2:0] S_DST_SEL = 3'd5;
    localparam logic [2:0] S_FWD     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.load    = in_valid && in_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SRC_CMP;
            end
            S_SRC_CMP:
            begin
                cmd.src_cmp = 1'b1;
                state_next  = S_SRC_SEL;
            end
            S_SRC_SEL:
            begin
                cmd.src_sel = 1'b1;
                state_next  = S_LEARN;
            end
            S_LEARN:
            begin
                cmd.learn  = 1'b1;
                state_next = S_DST_CMP;
            end
            S_DST_CMP:
            begin
                cmd.dst_cmp = 1'b1;
                state_next  = S_DST_SEL;
            end
            S_DST_SEL:
            begin
                cmd.dst_sel = 1'b1;
                state_next  = S_FWD;
            end
            S_FWD:
            begin
                // hold here until the result register can take the transfer
                if (status.out_free)
                begin
                    cmd.fwd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/lbf_datapath.sv
`include "assert_macros.svh"

module lbf_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lbf_pkg::ctrl_cmd_t     cmd,
    output lbf_pkg::dp_status_t    status,
    input  logic                   cfg_we,
    input  lbf_pkg::cfg_t          cfg_wdata,
    input  lbf_pkg::addr_t         source_address,
    input  lbf_pkg::addr_t         destination_address,
    input  lbf_pkg::port_t         arrival_port,
    lbf_out_if.source              res_out
);

    // item registers
    lbf_pkg::addr_t   src_reg;
    lbf_pkg::addr_t   dst_reg;
    lbf_pkg::port_t   port_reg;

    // address table
    lbf_pkg::row_vec_t entry_valid_reg;
    lbf_pkg::addr_t   entry_addr_reg  [lbf_pkg::TABLE_ENTRIES];
    lbf_pkg::port_t   entry_port_reg  [lbf_pkg::TABLE_ENTRIES];
    lbf_pkg::conf_t   entry_conf_reg  [lbf_pkg::TABLE_ENTRIES];
    lbf_pkg::stat_t   entry_uses_reg  [lbf_pkg::TABLE_ENTRIES];
    lbf_pkg::mask_t   entry_alts_reg  [lbf_pkg::TABLE_ENTRIES];
    lbf_pkg::cnt_t    entry_count_reg;

    // search pipeline
    lbf_pkg::row_vec_t match_reg;
    lbf_pkg::row_vec_t free_reg;
    lbf_pkg::idx_t    sel_idx_reg;
    logic             sel_hit_reg;
    lbf_pkg::idx_t    free_idx_reg;
    logic             free_ok_reg;

    logic             learned_reg;
    logic             full_reg;
    logic             alt_reg;

    lbf_pkg::stat_t   seen_reg;
    lbf_pkg::stat_t   routed_reg;
    lbf_pkg::stat_t   flooded_reg;
    lbf_pkg::cfg_t    ports_reg;

    logic             out_valid_reg;

    lbf_pkg::addr_t   cmp_addr;
    lbf_pkg::row_vec_t match_vec;
    lbf_pkg::idx_t    enc_idx;
    logic             enc_hit;
    lbf_pkg::idx_t    free_idx;
    logic             free_ok;

    lbf_pkg::port_t   rd_port;
    lbf_pkg::conf_t   rd_conf;
    lbf_pkg::stat_t   rd_uses;
    lbf_pkg::mask_t   rd_alts;
    lbf_pkg::mask_t   arr_bit;
    lbf_pkg::mask_t   amask;
    logic             single_port;
    lbf_pkg::stat_t   uses_next;

    assign status.out_free = !out_valid_reg || res_out.ready;

    assign cmp_addr = cmd.src_cmp ? src_reg : dst_reg;

    always_comb
    begin
        for (int i = 0; i < lbf_pkg::TABLE_ENTRIES; i++)
            match_vec[i] = entry_valid_reg[i] && (entry_addr_reg[i] == cmp_addr);
    end

    // lowest matching and lowest free entry
    always_comb
    begin
        enc_idx  = '0;
        enc_hit  = 1'b0;
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = lbf_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                enc_idx = lbf_pkg::IDX_W'(i);
                enc_hit = 1'b1;
            end
            if (free_reg[i])
            begin
                free_idx = lbf_pkg::IDX_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    assign rd_port     = entry_port_reg[sel_idx_reg];
    assign rd_conf     = entry_conf_reg[sel_idx_reg];
    assign rd_uses     = entry_uses_reg[sel_idx_reg];
    assign rd_alts     = entry_alts_reg[sel_idx_reg];
    assign arr_bit     = lbf_pkg::mask_t'(1) << port_reg;
    assign amask       = lbf_pkg::active_mask(ports_reg);
    assign single_port = (amask == lbf_pkg::MASK_SINGLE);
    assign uses_next   = rd_uses + lbf_pkg::stat_t'(1);

    // payload, search, table entry and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg  <= source_address;
            dst_reg  <= destination_address;
            port_reg <= arrival_port;
        end
        if (cmd.src_cmp || cmd.dst_cmp)
        begin
            match_reg <= match_vec;
            free_reg  <= ~entry_valid_reg;
        end
        if (cmd.src_sel || cmd.dst_sel)
        begin
            sel_idx_reg  <= enc_idx;
            sel_hit_reg  <= enc_hit;
            free_idx_reg <= free_idx;
            free_ok_reg  <= free_ok;
        end
        if (cmd.learn)
        begin
            learned_reg <= 1'b0;
            full_reg    <= 1'b0;
            alt_reg     <= 1'b0;
            if (sel_hit_reg)
            begin
                if (rd_port == port_reg)
                begin
                    if (rd_conf < lbf_pkg::CONF_MAX)
                        entry_conf_reg[sel_idx_reg] <= rd_conf + lbf_pkg::conf_t'(1);
                end
                else if ({1'b0, port_reg} < (lbf_pkg::PORT_W + 1)'(lbf_pkg::PORT_COUNT))
                begin
                    if ((rd_alts & arr_bit) == '0)
                    begin
                        entry_alts_reg[sel_idx_reg] <= rd_alts | arr_bit;
                        alt_reg <= 1'b1;
                    end
                end
            end
            else if (free_ok_reg)
            begin
                entry_addr_reg[free_idx_reg] <= src_reg;
                entry_port_reg[free_idx_reg] <= port_reg;
                entry_conf_reg[free_idx_reg] <= lbf_pkg::CONF_NEW;
                entry_uses_reg[free_idx_reg] <= '0;
                entry_alts_reg[free_idx_reg] <= '0;
                learned_reg <= 1'b1;
            end
            else
            begin
                full_reg <= 1'b1;
            end
        end
        if (cmd.fwd)
        begin
            res_out.new_route_learned   <= learned_reg;
            res_out.learn_table_full    <= full_reg;
            res_out.alternate_port_seen <= alt_reg;
            res_out.packets_seen        <= seen_reg + lbf_pkg::stat_t'(1);
            res_out.routes_known        <= entry_count_reg;
            res_out.packets_routed      <= routed_reg;
            res_out.packets_flooded     <= flooded_reg;
            res_out.route_hit           <= 1'b0;
            res_out.route_confidence    <= '0;
            res_out.route_uses          <= '0;
            if (single_port)
            begin
                res_out.forward_mask <= (port_reg == '0) ? lbf_pkg::MASK_SINGLE : '0;
            end
            else if (sel_hit_reg)
            begin
                entry_uses_reg[sel_idx_reg] <= uses_next;
                res_out.route_hit           <= 1'b1;
                res_out.route_confidence    <= rd_conf;
                res_out.route_uses          <= uses_next;
                res_out.packets_routed      <= routed_reg + lbf_pkg::stat_t'(1);
                res_out.forward_mask        <= (lbf_pkg::mask_t'(1) << rd_port) & amask;
            end
            else
            begin
                res_out.packets_flooded <= flooded_reg + lbf_pkg::stat_t'(1);
                res_out.forward_mask    <= amask & ~arr_bit;
            end
        end
    end

    // control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            entry_count_reg <= '0;
            seen_reg        <= '0;
            routed_reg      <= '0;
            flooded_reg     <= '0;
            ports_reg       <= lbf_pkg::PORTS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ports_reg <= cfg_wdata;
            if (cmd.learn && !sel_hit_reg && free_ok_reg)
            begin
                entry_valid_reg[free_idx_reg] <= 1'b1;
                entry_count_reg <= entry_count_reg + lbf_pkg::cnt_t'(1);
            end
            if (cmd.fwd)
            begin
                seen_reg <= seen_reg + lbf_pkg::stat_t'(1);
                if (!single_port && sel_hit_reg)
                    routed_reg <= routed_reg + lbf_pkg::stat_t'(1);
                if (!single_port && !sel_hit_reg)
                    flooded_reg <= flooded_reg + lbf_pkg::stat_t'(1);
            end
            priority if (cmd.fwd)
                out_valid_reg <= 1'b1;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res_out.valid = out_valid_reg;

    `LBF_ASSERT(a_count_matches_valid, $countones(entry_valid_reg) == int'(entry_count_reg), "entry count out of step with valid bits")
    `LBF_ASSERT(a_fwd_loads_result, cmd.fwd |=> out_valid_reg, "result not presented after forward step")
    `LBF_ASSERT_NEVER(a_learn_excl, out_valid_reg && res_out.new_route_learned && (res_out.learn_table_full || res_out.alternate_port_seen), "learn flags conflict")
    `LBF_ASSERT(a_miss_zero, (out_valid_reg && !res_out.route_hit) |-> (res_out.route_confidence == '0 && res_out.route_uses == '0), "miss carries entry data")

endmodule

### hdl/learning_bridge_forwarder.sv
// channel   dir  handshake      payload
// pkt_in    in   valid/ready    source_address, destination_address, arrival_port
// res_out   out  valid/ready    forward_mask, flags, confidence, uses, counters
// cfg       in   cfg_we         cfg_wdata = ports_in_use
//
// a header steps through accept, then source compare, source select, learn,
// destination compare, destination select, forward; the table search is a
// registered compare across all entries followed by a priority pick
// the next header is taken while the previous result still waits on res_out
// the forward step stalls while the result register is full and not being taken
// rst_n clears the table valid bits, counters and ports_in_use (back to 8)
module learning_bridge_forwarder (
    input  logic             clk,
    input  logic             rst_n,
    lbf_in_if.sink           pkt_in,
    lbf_out_if.source        res_out,
    input  logic             cfg_we,
    input  lbf_pkg::cfg_t    cfg_wdata
);

    lbf_pkg::ctrl_cmd_t  cmd;
    lbf_pkg::dp_status_t status;

    lbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt_in.valid),
        .in_ready (pkt_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lbf_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .source_address      (pkt_in.source_address),
        .destination_address (pkt_in.destination_address),
        .arrival_port        (pkt_in.arrival_port),
        .res_out             (res_out)
    );

endmodule
